@@ rtl/core/gbn_pkg.sv @@
// gbn_pkg: shared types and codes for the go-back-n sender window
// used by go_back_n_sender_window and gbn_alu; no dependencies
package gbn_pkg;

    localparam int SEQ_W   = 32;
    localparam int CMD_W   = 3;
    localparam int WSIZE_W = 5;
    localparam int RETRY_W = 8;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ACK     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REJECT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CORRUPT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_OTHER   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 1'd1;

    localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST = 5'd4;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 8'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SLIDE,
        ST_RESEND,
        ST_FILL,
        ST_STATUS
    } state_t;

    typedef enum logic [0:0] {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

@@ rtl/core/gbn_alu.sv @@
// gbn_alu: shared 32-bit add/subtract unit with carry out
// depends on gbn_pkg
module gbn_alu
    import gbn_pkg::*;
(
    input  alu_op_t          op,
    input  logic [SEQ_W-1:0] op_a,
    input  logic [SEQ_W-1:0] op_b,
    output logic [SEQ_W-1:0] sum,
    output logic             carry
);

    logic [SEQ_W-1:0] b_eff;
    logic             cin;

    always_comb begin
        case (op)
            ALU_ADD: begin
                b_eff = op_b;
                cin   = 1'b0;
            end
            ALU_SUB: begin
                b_eff = ~op_b;
                cin   = 1'b1;
            end
            default: begin
                b_eff = op_b;
                cin   = 1'b0;
            end
        endcase
    end

    // carry set on subtract means op_a >= op_b
    assign {carry, sum} = {1'b0, op_a} + {1'b0, b_eff} + {{SEQ_W{1'b0}}, cin};

endmodule

@@ rtl/core/go_back_n_sender_window.sv @@
// go_back_n_sender_window: go-back-n sender window controller, top level
// depends on gbn_pkg and gbn_alu
//
// One event word is taken at a time; s_ready is high only while the sequencer is idle.
// An event passes through a dispatch state, then a slide state on an in-window
// acknowledgement, and then emits its result words (send orders, or a single status word
// when nothing is sent). A refill that finds the window already full, or a resend with
// nothing outstanding, spends an extra step in its state without emitting a word. All
// sequence arithmetic goes through one shared 32-bit add/subtract unit, which computes
// each send_seq as base plus an offset, one per cycle while the output register can take
// a word. Results pass through an output register, so a new event is accepted while the
// final word of the previous one waits.
module go_back_n_sender_window
    import gbn_pkg::*;
#(
    parameter int WINDOW_MAX = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CMD_W-1:0]     s_command,
    input  logic [SEQ_W-1:0]     s_seq_num,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_send_valid,
    output logic [SEQ_W-1:0]     m_send_seq,
    output logic                 m_fresh,
    output logic                 m_reposition,
    output logic                 m_failed,
    output logic [RETRY_W-1:0]   m_retries_left,
    output logic                 m_last
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int EW = (CW > WSIZE_W) ? CW : WSIZE_W;

    state_t state_reg, state_next;

    logic [WSIZE_W-1:0] window_size_reg, window_size_next;
    logic [RETRY_W-1:0] retry_limit_reg, retry_limit_next;

    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [SEQ_W-1:0]   diff_reg, diff_next;
    logic [SEQ_W-1:0]   base_reg, base_next;
    logic [CW-1:0]      in_flight_reg, in_flight_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [RETRY_W-1:0] retries_reg, retries_next;
    logic               failed_reg, failed_next;
    logic               running_reg, running_next;
    logic               repos_reg, repos_next;
    logic               emitted_reg, emitted_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_send_valid_reg, m_send_valid_next;
    logic [SEQ_W-1:0]   m_send_seq_reg, m_send_seq_next;
    logic               m_fresh_reg, m_fresh_next;
    logic               m_reposition_reg, m_reposition_next;
    logic               m_failed_reg, m_failed_next;
    logic [RETRY_W-1:0] m_retries_reg, m_retries_next;
    logic               m_last_reg, m_last_next;

    alu_op_t            alu_op;
    logic [SEQ_W-1:0]   alu_a, alu_b, alu_sum;
    logic               alu_carry;

    logic [EW-1:0]      ws_ext;
    logic [CW-1:0]      win;
    logic [RETRY_W-1:0] lim;
    logic [RETRY_W-1:0] dec_retries;
    logic               active;
    logic               out_free;
    logic [CW-1:0]      pop;
    logic               fill_room;
    logic               fill_last;
    logic               resend_end;
    logic               resend_last;

    gbn_alu u_alu (
        .op    (alu_op),
        .op_a  (alu_a),
        .op_b  (alu_b),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    // effective window and retry limit
    assign ws_ext = EW'(window_size_reg);
    always_comb begin
        if (window_size_reg == '0) begin
            win = CW'(1);
        end else if (ws_ext > EW'(WINDOW_MAX)) begin
            win = CW'(WINDOW_MAX);
        end else begin
            win = ws_ext[CW-1:0];
        end
    end

    assign lim         = (retry_limit_reg == '0) ? RETRY_W'(1) : retry_limit_reg;
    assign dec_retries = (retries_reg == '0) ? '0 : retries_reg - RETRY_W'(1);
    assign active      = running_reg && !failed_reg;
    assign out_free    = !m_valid_reg || m_ready;

    assign pop = (diff_reg >= SEQ_W'(in_flight_reg)) ? in_flight_reg
                                                       : diff_reg[CW-1:0] + CW'(1);

    assign fill_room   = in_flight_reg < win;
    assign fill_last   = (in_flight_reg + CW'(1)) >= win;
    assign resend_end  = (idx_reg + CW'(1)) == in_flight_reg;
    assign resend_last = resend_end && !fill_room;

    // shared unit operand select
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = base_reg;
        alu_b  = SEQ_W'(in_flight_reg);
        case (state_reg)
            ST_DISPATCH: begin
                alu_op = ALU_SUB;
                alu_a  = seq_reg;
                alu_b  = base_reg;
            end
            ST_SLIDE: begin
                alu_b = SEQ_W'(pop);
            end
            ST_RESEND: begin
                alu_b = SEQ_W'(idx_reg);
            end
            default: begin
                alu_b = SEQ_W'(in_flight_reg);
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (cmd_reg == CMD_START) begin
                    state_next = ST_FILL;
                end else if (!active) begin
                    state_next = ST_STATUS;
                end else begin
                    case (cmd_reg)
                        CMD_ACK:     state_next = alu_carry ? ST_SLIDE : ST_STATUS;
                        CMD_REJECT:  state_next = alu_carry ? ST_RESEND : ST_FILL;
                        CMD_TIMEOUT: state_next = (dec_retries == '0) ? ST_STATUS : ST_FILL;
                        CMD_CORRUPT: begin
                            state_next = (lim == RETRY_W'(1)) ? ST_STATUS : ST_FILL;
                        end
                        default:     state_next = ST_STATUS;
                    endcase
                end
            end
            ST_SLIDE: begin
                state_next = ST_FILL;
            end
            ST_RESEND: begin
                if (in_flight_reg == '0) begin
                    state_next = ST_FILL;
                end else if (out_free && resend_end) begin
                    state_next = resend_last ? ST_IDLE : ST_FILL;
                end
            end
            ST_FILL: begin
                if (fill_room) begin
                    if (out_free && fill_last) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = emitted_reg ? ST_IDLE : ST_STATUS;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and output word
    always_comb begin
        window_size_next = window_size_reg;
        retry_limit_next = retry_limit_reg;
        cmd_next         = cmd_reg;
        seq_next         = seq_reg;
        diff_next        = diff_reg;
        base_next        = base_reg;
        in_flight_next   = in_flight_reg;
        idx_next         = idx_reg;
        retries_next     = retries_reg;
        failed_next      = failed_reg;
        running_next     = running_reg;
        repos_next       = repos_reg;
        emitted_next     = emitted_reg;

        m_valid_next      = m_valid_reg && !m_ready;
        m_send_valid_next = m_send_valid_reg;
        m_send_seq_next   = m_send_seq_reg;
        m_fresh_next      = m_fresh_reg;
        m_reposition_next = m_reposition_reg;
        m_failed_next     = m_failed_reg;
        m_retries_next    = m_retries_reg;
        m_last_next       = m_last_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_WINDOW_SIZE: window_size_next = cfg_wr_data[WSIZE_W-1:0];
                REG_RETRY_LIMIT: retry_limit_next = cfg_wr_data[RETRY_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next     = s_command;
                    seq_next     = s_seq_num;
                    emitted_next = 1'b0;
                    repos_next   = 1'b0;
                end
            end
            ST_DISPATCH: begin
                if (cmd_reg == CMD_START) begin
                    running_next   = 1'b1;
                    failed_next    = 1'b0;
                    base_next      = '0;
                    in_flight_next = '0;
                    retries_next   = lim;
                end else if (active) begin
                    case (cmd_reg)
                        CMD_ACK: begin
                            retries_next = lim;
                            diff_next    = alu_sum;
                        end
                        CMD_REJECT: begin
                            retries_next = lim;
                            if (alu_carry) begin
                                idx_next = '0;
                            end else begin
                                base_next      = seq_reg;
                                in_flight_next = '0;
                                repos_next     = 1'b1;
                            end
                        end
                        CMD_TIMEOUT: begin
                            retries_next = dec_retries;
                            if (dec_retries == '0) begin
                                failed_next = 1'b1;
                            end
                        end
                        CMD_CORRUPT: begin
                            retries_next = lim - RETRY_W'(1);
                            if (lim == RETRY_W'(1)) begin
                                failed_next = 1'b1;
                            end
                        end
                        CMD_OTHER: begin
                            retries_next = lim;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SLIDE: begin
                base_next      = alu_sum;
                in_flight_next = in_flight_reg - pop;
            end
            ST_RESEND: begin
                if (in_flight_reg != '0 && out_free) begin
                    m_valid_next      = 1'b1;
                    m_send_valid_next = 1'b1;
                    m_send_seq_next   = alu_sum;
                    m_fresh_next      = 1'b0;
                    m_reposition_next = 1'b0;
                    m_failed_next     = failed_reg;
                    m_retries_next    = retries_reg;
                    m_last_next       = resend_last;
                    idx_next          = idx_reg + CW'(1);
                    emitted_next      = 1'b1;
                end
            end
            ST_FILL: begin
                if (fill_room && out_free) begin
                    m_valid_next      = 1'b1;
                    m_send_valid_next = 1'b1;
                    m_send_seq_next   = alu_sum;
                    m_fresh_next      = 1'b1;
                    m_reposition_next = repos_reg;
                    m_failed_next     = failed_reg;
                    m_retries_next    = retries_reg;
                    m_last_next       = fill_last;
                    in_flight_next    = in_flight_reg + CW'(1);
                    repos_next        = 1'b0;
                    emitted_next      = 1'b1;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_send_valid_next = 1'b0;
                    m_send_seq_next   = '0;
                    m_fresh_next      = 1'b0;
                    m_reposition_next = 1'b0;
                    m_failed_next     = failed_reg;
                    m_retries_next    = retries_reg;
                    m_last_next       = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            window_size_reg <= WINDOW_SIZE_RST;
            retry_limit_reg <= RETRY_LIMIT_RST;
            base_reg        <= '0;
            in_flight_reg   <= '0;
            retries_reg     <= '0;
            failed_reg      <= 1'b0;
            running_reg     <= 1'b0;
            repos_reg       <= 1'b0;
            emitted_reg     <= 1'b0;
            idx_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            window_size_reg <= window_size_next;
            retry_limit_reg <= retry_limit_next;
            base_reg        <= base_next;
            in_flight_reg   <= in_flight_next;
            retries_reg     <= retries_next;
            failed_reg      <= failed_next;
            running_reg     <= running_next;
            repos_reg       <= repos_next;
            emitted_reg     <= emitted_next;
            idx_reg         <= idx_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        cmd_reg          <= cmd_next;
        seq_reg          <= seq_next;
        diff_reg         <= diff_next;
        m_send_valid_reg <= m_send_valid_next;
        m_send_seq_reg   <= m_send_seq_next;
        m_fresh_reg      <= m_fresh_next;
        m_reposition_reg <= m_reposition_next;
        m_failed_reg     <= m_failed_next;
        m_retries_reg    <= m_retries_next;
        m_last_reg       <= m_last_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_send_valid   = m_send_valid_reg;
    assign m_send_seq     = m_send_seq_reg;
    assign m_fresh        = m_fresh_reg;
    assign m_reposition   = m_reposition_reg;
    assign m_failed       = m_failed_reg;
    assign m_retries_left = m_retries_reg;
    assign m_last         = m_last_reg;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking testbench for go_back_n_sender_window, the go-back-n sender window
// drives link events with random gaps, predicts every send order and status word, checks them
// depends on gbn_pkg and go_back_n_sender_window
module tb_top;
    import gbn_pkg::*;

    localparam int WINDOW_MAX = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_HOLD = 400;
    localparam int PHASE_EVENTS = 50;
    localparam int RANDOM_PHASES = 9;
    localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;

    typedef struct packed {
        logic               send_valid;
        logic [SEQ_W-1:0]   send_seq;
        logic               fresh;
        logic               reposition;
        logic               failed;
        logic [RETRY_W-1:0] retries_left;
        logic               last;
    } send_order_t;

    typedef struct packed {
        logic [SEQ_W-1:0]   base;
        logic [WSIZE_W-1:0] in_flight;
        logic [RETRY_W-1:0] retries;
        logic               failed;
        logic               running;
        logic [WSIZE_W-1:0] wsize;
        logic [RETRY_W-1:0] rlimit;
    } window_model_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SEQ_W-1:0] seq;
    } link_event_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_command = '0;
    logic [SEQ_W-1:0]     s_seq_num = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_send_valid;
    logic [SEQ_W-1:0]     m_send_seq;
    logic                 m_fresh;
    logic                 m_reposition;
    logic                 m_failed;
    logic [RETRY_W-1:0]   m_retries_left;
    logic                 m_last;

    link_event_t   event_queue[$];
    send_order_t   expected_orders[$];
    send_order_t   step_words[$];
    window_model_t gen_model;
    window_model_t chk_model;

    int unsigned words_queued = 0;
    int unsigned words_offered = 0;
    int unsigned words_taken = 0;
    int unsigned results_taken = 0;
    int unsigned results_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    int unsigned hold_left = 0;
    bit          quiet_tx = 1'b0;
    bit          quiet_rx = 1'b0;
    bit          hold_request = 1'b0;
    bit          hold_done = 1'b0;
    logic        tx_next;
    link_event_t cur_event;

    go_back_n_sender_window #(
        .WINDOW_MAX(WINDOW_MAX)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_seq_num     (s_seq_num),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_send_valid  (m_send_valid),
        .m_send_seq    (m_send_seq),
        .m_fresh       (m_fresh),
        .m_reposition  (m_reposition),
        .m_failed      (m_failed),
        .m_retries_left(m_retries_left),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("go_back_n_sender_window verification failed");
            $finish;
        end
    end

    function automatic int unsigned draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic logic [WSIZE_W-1:0] eff_window(logic [WSIZE_W-1:0] ws);
        if (ws == '0)
            return WSIZE_W'(1);
        if (ws > WSIZE_W'(WINDOW_MAX))
            return WSIZE_W'(WINDOW_MAX);
        return ws;
    endfunction

    task automatic reset_window(output window_model_t m);
        m = '0;
        m.wsize = WINDOW_SIZE_RST;
        m.rlimit = RETRY_LIMIT_RST;
    endtask

    task automatic apply_register(inout window_model_t m, input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] data);
        if (idx == REG_WINDOW_SIZE)
            m.wsize = data[WSIZE_W-1:0];
        else if (idx == REG_RETRY_LIMIT)
            m.rlimit = data[RETRY_W-1:0];
    endtask

    task automatic emit_send(input logic [SEQ_W-1:0] seq, input logic fr, input logic rp);
        send_order_t w;
        w = '0;
        w.send_valid = 1'b1;
        w.send_seq = seq;
        w.fresh = fr;
        w.reposition = rp;
        step_words = {step_words, w};
    endtask

    task automatic refill(inout window_model_t m, input logic first_repos);
        logic rp;
        rp = first_repos;
        while (m.in_flight < eff_window(m.wsize)) begin
            emit_send(m.base + SEQ_W'(m.in_flight), 1'b1, rp);
            rp = 1'b0;
            m.in_flight = m.in_flight + WSIZE_W'(1);
        end
    endtask

    // leaves the words that one link event produces in step_words
    task automatic advance_window(inout window_model_t m, input logic [CMD_W-1:0] cmd,
                                  input logic [SEQ_W-1:0] seq);
        logic [SEQ_W-1:0]   diff;
        logic [WSIZE_W-1:0] pop;
        logic [RETRY_W-1:0] lim;
        send_order_t        w;
        int                 i;
        step_words.delete();
        lim = (m.rlimit == '0) ? 8'd1 : m.rlimit;
        if (cmd == CMD_START) begin
            m.running = 1'b1;
            m.failed = 1'b0;
            m.base = '0;
            m.in_flight = '0;
            m.retries = lim;
            refill(m, 1'b0);
        end else if (m.running && !m.failed) begin
            case (cmd)
                CMD_ACK: begin
                    m.retries = lim;
                    if (seq >= m.base) begin
                        diff = seq - m.base;
                        pop = (diff >= SEQ_W'(m.in_flight)) ? m.in_flight
                                                             : diff[WSIZE_W-1:0] + WSIZE_W'(1);
                        m.base = m.base + SEQ_W'(pop);
                        m.in_flight = m.in_flight - pop;
                        refill(m, 1'b0);
                    end
                end
                CMD_REJECT: begin
                    m.retries = lim;
                    if (seq >= m.base) begin
                        for (i = 0; i < int'(m.in_flight); i++)
                            emit_send(m.base + SEQ_W'(i), 1'b0, 1'b0);
                        refill(m, 1'b0);
                    end else begin
                        m.base = seq;
                        m.in_flight = '0;
                        refill(m, 1'b1);
                    end
                end
                CMD_TIMEOUT, CMD_CORRUPT: begin
                    if (cmd == CMD_TIMEOUT)
                        m.retries = (m.retries == '0) ? '0 : m.retries - RETRY_W'(1);
                    else
                        m.retries = lim - RETRY_W'(1);
                    if (m.retries == '0)
                        m.failed = 1'b1;
                    else
                        refill(m, 1'b0);
                end
                CMD_OTHER: begin
                    m.retries = lim;
                end
                default: begin
                end
            endcase
        end
        if (step_words.size() == 0) begin
            w = '0;
            step_words = {step_words, w};
        end
        for (i = 0; i < step_words.size(); i++) begin
            w = step_words[i];
            w.failed = m.failed;
            w.retries_left = m.retries;
            w.last = (i == step_words.size() - 1);
            step_words[i] = w;
        end
    endtask

    task automatic queue_event(input logic [CMD_W-1:0] cmd, input logic [SEQ_W-1:0] seq);
        link_event_t e;
        e.cmd = cmd;
        e.seq = seq;
        event_queue = {event_queue, e};
        words_queued++;
        advance_window(gen_model, cmd, seq);
    endtask

    // mostly well-formed traffic around the current window, some noise
    task automatic queue_random_event();
        int unsigned r;
        int unsigned span;
        r = $urandom_range(0, 99);
        span = (gen_model.base < 32) ? gen_model.base : 32;
        if (!gen_model.running || gen_model.failed) begin
            if (r < 80)
                queue_event(CMD_START, $urandom);
            else if (r < 88)
                queue_event(r[0] ? CMD_RSVD_A : CMD_RSVD_B, $urandom);
            else
                queue_event(CMD_W'($urandom_range(CMD_ACK, CMD_OTHER)), $urandom);
        end else if (r < 36) begin
            queue_event(CMD_ACK, gen_model.base + $urandom_range(0, gen_model.in_flight));
        end else if (r < 41) begin
            if (span != 0)
                queue_event(CMD_ACK, gen_model.base - $urandom_range(1, span));
            else
                queue_event(CMD_ACK, $urandom);
        end else if (r < 45) begin
            queue_event(CMD_ACK, $urandom);
        end else if (r < 57) begin
            queue_event(CMD_REJECT, gen_model.base + $urandom_range(0, gen_model.in_flight + 3));
        end else if (r < 65) begin
            if (span != 0)
                queue_event(CMD_REJECT, gen_model.base - $urandom_range(1, span));
            else
                queue_event(CMD_REJECT, '0);
        end else if (r < 75) begin
            queue_event(CMD_TIMEOUT, $urandom);
        end else if (r < 80) begin
            queue_event(CMD_CORRUPT, $urandom);
        end else if (r < 86) begin
            queue_event(CMD_OTHER, $urandom);
        end else if (r < 89) begin
            queue_event(CMD_START, $urandom);
        end else if (r < 93) begin
            queue_event(r[0] ? CMD_RSVD_A : CMD_RSVD_B, $urandom);
        end else begin
            queue_event(CMD_REJECT, $urandom);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_index <= idx;
        cfg_wr_data <= data;
        cfg_wr_en <= 1'b1;
        apply_register(gen_model, idx, data);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (words_taken != words_queued || expected_orders.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic void check_field(string name, logic [SEQ_W-1:0] want,
                                        logic [SEQ_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // event word driver
    always @(negedge aclk) begin
        if (aresetn) begin
            tx_next = s_valid;
            if (s_valid && words_taken != words_offered) begin
                words_offered++;
                tx_next = 1'b0;
                tx_gap = draw_gap(quiet_tx);
            end
            if (!tx_next) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                end else if (event_queue.size() != 0) begin
                    cur_event = event_queue[0];
                    event_queue.delete(0);
                    s_command <= cur_event.cmd;
                    s_seq_num <= cur_event.seq;
                    tx_next = 1'b1;
                end
            end
            s_valid <= tx_next;
        end
    end

    // result word receiver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (results_taken != results_seen) begin
                results_seen = results_taken;
                rx_gap = draw_gap(quiet_rx);
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor: checks result words, predicts on accepted event words
    always @(posedge aclk) begin : word_monitor
        send_order_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_taken++;
                if (expected_orders.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result word with nothing expected, expected none, actual %0h",
                             $time, m_send_seq);
                end else begin
                    want = expected_orders[0];
                    expected_orders.delete(0);
                    check_field("send_valid", SEQ_W'(want.send_valid), SEQ_W'(m_send_valid));
                    check_field("send_seq", want.send_seq, m_send_seq);
                    check_field("fresh", SEQ_W'(want.fresh), SEQ_W'(m_fresh));
                    check_field("reposition", SEQ_W'(want.reposition), SEQ_W'(m_reposition));
                    check_field("failed", SEQ_W'(want.failed), SEQ_W'(m_failed));
                    check_field("retries_left", SEQ_W'(want.retries_left),
                                SEQ_W'(m_retries_left));
                    check_field("last", SEQ_W'(want.last), SEQ_W'(m_last));
                end
            end
            if (s_valid && s_ready) begin
                words_taken++;
                advance_window(chk_model, s_command, s_seq_num);
                expected_orders = {expected_orders, step_words};
            end
            if (cfg_wr_en)
                apply_register(chk_model, cfg_index, cfg_wr_data);
        end
    end

    initial begin
        int p;
        int n;
        logic [CFG_W-1:0] win_data;
        logic [CFG_W-1:0] lim_data;
        reset_window(gen_model);
        reset_window(chk_model);
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: events before start, window sliding, rejects, retries, restart
        queue_event(CMD_ACK, '0);
        queue_event(CMD_RSVD_A, '0);
        queue_event(CMD_START, '0);
        queue_event(CMD_ACK, 32'd0);
        queue_event(CMD_ACK, 32'd3);
        queue_event(CMD_ACK, 32'd1);
        queue_event(CMD_REJECT, 32'hFFFF_FFFF);
        queue_event(CMD_REJECT, 32'd2);
        queue_event(CMD_OTHER, 32'd0);
        queue_event(CMD_TIMEOUT, 32'd0);
        queue_event(CMD_CORRUPT, 32'd0);
        queue_event(CMD_RSVD_B, 32'hFFFF_FFFF);
        queue_event(CMD_ACK, 32'h5555_5555);
        queue_event(CMD_REJECT, 32'hAAAA_AAAA);
        queue_event(CMD_ACK, 32'hFFFF_FFFF);
        queue_event(CMD_START, 32'hFFFF_FFFF);
        queue_event(CMD_TIMEOUT, 32'd0);
        wait_drained();

        // directed: retry exhaustion with a limit of one
        write_reg(REG_RETRY_LIMIT, 8'd1);
        queue_event(CMD_START, '0);
        queue_event(CMD_CORRUPT, '0);
        queue_event(CMD_ACK, '0);
        queue_event(CMD_TIMEOUT, '0);
        queue_event(CMD_START, '0);
        queue_event(CMD_TIMEOUT, '0);
        queue_event(CMD_OTHER, '0);
        queue_event(CMD_START, '0);
        wait_drained();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            quiet_tx = 1'b0;
            quiet_rx = 1'b0;
            case (p)
                0: begin
                    win_data = 8'd16;
                    lim_data = 8'd255;
                    quiet_tx = 1'b1;
                    hold_request = 1'b1;
                end
                1: begin
                    win_data = 8'd0;
                    lim_data = 8'd0;
                end
                2: begin
                    win_data = 8'd31;
                    lim_data = 8'd2;
                    quiet_rx = 1'b1;
                end
                3: begin
                    win_data = 8'hE7;
                    lim_data = 8'd200;
                end
                4: begin
                    win_data = 8'd17;
                    lim_data = 8'd1;
                    quiet_tx = 1'b1;
                    quiet_rx = 1'b1;
                end
                5: begin
                    win_data = 8'd1;
                    lim_data = 8'd3;
                end
                6: begin
                    win_data = 8'd5;
                    lim_data = 8'h80;
                end
                7: begin
                    win_data = 8'd2;
                    lim_data = 8'd50;
                end
                default: begin
                    win_data = 8'd16;
                    lim_data = 8'd10;
                end
            endcase
            write_reg(REG_WINDOW_SIZE, win_data);
            write_reg(REG_RETRY_LIMIT, lim_data);
            for (n = 0; n < PHASE_EVENTS; n++)
                queue_random_event();
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("go_back_n_sender_window verification clean");
        end else begin
            $display("go_back_n_sender_window verification failed");
        end
        $finish;
    end

endmodule
